@@ src/llqm_pkg.sv @@
// Shared types, constants and helpers for the linked list queue manager.
// No dependencies; llqm_ctrl, llqm_dp and the top level import this package.
`default_nettype none

package llqm_pkg;

    localparam int NODE_COUNT = 64;
    localparam int LIST_COUNT = 8;
    localparam int NODE_W     = 6;
    localparam int LIST_W     = 3;
    localparam int CMD_W      = 3;
    localparam int LINK_W     = 7;
    localparam int CNT_W      = 7;
    localparam int COUNT_MAX  = 127;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_count;

    // null link / empty list marker
    localparam t_link NIL = LINK_W'(NODE_COUNT);

    typedef enum logic [CMD_W-1:0] {
        CMD_RESET_LIST,
        CMD_RESET_NODE,
        CMD_INSERT_FRONT,
        CMD_APPEND,
        CMD_EXTRACT,
        CMD_POP_FRONT,
        CMD_INSERT_AFTER,
        CMD_QUERY
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WR1,
        S_WR2,
        S_FETCH,
        S_DONE
    } t_state;

    // controller to datapath strobes
    typedef struct packed {
        logic capture;
        logic rd_tgt;
        logic wr1;
        logic wr2;
        logic rd_node;
        logic load_out;
    } t_dp_ctl;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic is_node(t_link v);
        return v < LINK_W'(NODE_COUNT);
    endfunction

    function automatic t_node node_of(t_link v);
        return v[NODE_W-1:0];
    endfunction

    function automatic t_link to_link(t_node v);
        return LINK_W'(v);
    endfunction

endpackage

`default_nettype wire

@@ src/llqm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module llqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/llqm_ctrl.sv @@
// Command sequencer for the linked list queue manager: read, two write slots,
// read back, result load. Depends on llqm_pkg.
`default_nettype none

module llqm_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire llqm_pkg::t_dp_stat i_stat,
    output logic                    o_in_stall,
    output llqm_pkg::t_dp_ctl       o_ctl
);

    import llqm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_ctl.rd_tgt = 1'b1;
                n_state      = S_WR1;
            end
            S_WR1: begin
                o_ctl.wr1 = 1'b1;
                n_state   = S_WR2;
            end
            S_WR2: begin
                o_ctl.wr2 = 1'b1;
                n_state   = S_FETCH;
            end
            S_FETCH: begin
                o_ctl.rd_node = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // hold until the result register can take the transaction
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/llqm_dp.sv @@
// Datapath of the linked list queue manager: list registers, in-list flags,
// next/prev link RAMs with per-entry valid bits, result register.
// Depends on llqm_pkg and llqm_ram.
`default_nettype none

module llqm_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire llqm_pkg::t_dp_ctl             i_ctl,
    output llqm_pkg::t_dp_stat                 o_stat,
    input  wire logic [llqm_pkg::CMD_W-1:0]    i_command,
    input  wire logic [llqm_pkg::LIST_W-1:0]   i_list_id,
    input  wire logic [llqm_pkg::NODE_W-1:0]   i_node_id,
    input  wire logic [llqm_pkg::NODE_W-1:0]   i_anchor_id,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_accepted,
    output logic      [llqm_pkg::NODE_W-1:0]   o_popped_node,
    output logic                               o_popped_valid,
    output logic      [llqm_pkg::NODE_W-1:0]   o_head_node,
    output logic                               o_head_valid,
    output logic      [llqm_pkg::NODE_W-1:0]   o_tail_node,
    output logic                               o_tail_valid,
    output logic      [llqm_pkg::CNT_W-1:0]    o_entry_count,
    output logic      [llqm_pkg::NODE_W-1:0]   o_next_node,
    output logic                               o_next_valid,
    output logic      [llqm_pkg::NODE_W-1:0]   o_prev_node,
    output logic                               o_prev_valid
);

    import llqm_pkg::*;

    // captured command
    t_cmd                r_cmd;
    logic [LIST_W-1:0]   r_lid;
    t_node               r_nid;
    t_node               r_aid;

    // list and node state
    t_link               r_head [LIST_COUNT];
    t_link               r_tail [LIST_COUNT];
    t_count              r_count [LIST_COUNT];
    logic [NODE_COUNT-1:0] r_inl;
    logic [NODE_COUNT-1:0] r_nvld;
    logic [NODE_COUNT-1:0] r_pvld;
    logic                r_nrv;
    logic                r_prv;

    // per-command result bits
    logic                r_acc;
    t_node               r_pop_node;
    logic                r_pop_vld;

    // result register
    logic                r_out_vld;
    logic                r_o_acc;
    t_node               r_o_pop_node;
    logic                r_o_pop_vld;
    t_node               r_o_head;
    logic                r_o_head_vld;
    t_node               r_o_tail;
    logic                r_o_tail_vld;
    t_count              r_o_count;
    t_node               r_o_next;
    logic                r_o_next_vld;
    t_node               r_o_prev;
    logic                r_o_prev_vld;

    t_link               w_next_q;
    t_link               w_prev_q;
    t_link               rd_next;
    t_link               rd_prev;
    t_link               cur_head;
    t_link               cur_tail;
    t_count              cur_cnt;
    t_count              cnt_up;
    t_count              cnt_dn;
    t_node               u_node;
    t_node               tgt_addr;
    t_node               rd_addr;
    logic                rd_en;
    logic                lok;
    logic                nok;
    logic                aok;
    logic                go;

    logic                n1_we, n2_we, p1_we, p2_we;
    t_node               n1_addr, n2_addr, p1_addr, p2_addr;
    t_link               n1_data, n2_data, p1_data, p2_data;
    logic                next_we, prev_we;
    t_node               next_waddr, prev_waddr;
    t_link               next_wdata, prev_wdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= t_cmd'(i_command);
            r_lid <= i_list_id;
            r_nid <= i_node_id;
            r_aid <= i_anchor_id;
        end
    end

    assign lok      = {1'b0, r_lid} < (LIST_W+1)'(LIST_COUNT);
    assign nok      = is_node(to_link(r_nid));
    assign aok      = is_node(to_link(r_aid));
    assign cur_head = r_head[r_lid];
    assign cur_tail = r_tail[r_lid];
    assign cur_cnt  = r_count[r_lid];
    assign cnt_up   = (cur_cnt < CNT_W'(COUNT_MAX)) ? cur_cnt + CNT_W'(1) : cur_cnt;
    assign cnt_dn   = (cur_cnt != '0) ? cur_cnt - CNT_W'(1) : cur_cnt;
    // a never-written link entry reads as null
    assign rd_next  = r_nrv ? w_next_q : NIL;
    assign rd_prev  = r_prv ? w_prev_q : NIL;
    assign u_node   = (r_cmd == CMD_POP_FRONT) ? node_of(cur_head) : r_nid;

    always_comb begin
        case (r_cmd)
            CMD_RESET_LIST:   go = lok;
            CMD_RESET_NODE:   go = lok && nok;
            CMD_INSERT_FRONT: go = lok && nok && !r_inl[r_nid];
            CMD_APPEND:       go = lok && nok && !r_inl[r_nid];
            CMD_EXTRACT:      go = lok && nok && r_inl[r_nid];
            CMD_POP_FRONT:    go = lok && is_node(cur_head);
            CMD_INSERT_AFTER: go = lok && nok && aok && !r_inl[r_nid] && r_inl[r_aid];
            CMD_QUERY:        go = lok;
            default:          go = 1'b0;
        endcase
    end

    // read address: the node whose links the command needs, then node_id for the result
    always_comb begin
        case (r_cmd)
            CMD_POP_FRONT:    tgt_addr = node_of(cur_head);
            CMD_INSERT_AFTER: tgt_addr = r_aid;
            default:          tgt_addr = r_nid;
        endcase
    end

    assign rd_en   = i_ctl.rd_tgt || i_ctl.rd_node;
    assign rd_addr = i_ctl.rd_node ? r_nid : tgt_addr;

    // two ordered write slots per link memory
    always_comb begin
        n1_we = 1'b0; n1_addr = r_nid; n1_data = NIL;
        n2_we = 1'b0; n2_addr = r_nid; n2_data = NIL;
        p1_we = 1'b0; p1_addr = r_nid; p1_data = NIL;
        p2_we = 1'b0; p2_addr = r_nid; p2_data = NIL;
        if (go) begin
            case (r_cmd)
                CMD_RESET_NODE: begin
                    n1_we = 1'b1;
                    p1_we = 1'b1;
                end
                CMD_INSERT_FRONT: begin
                    n1_we   = 1'b1;
                    n1_data = cur_head;
                    p1_we   = 1'b1;
                    p2_we   = is_node(cur_head);
                    p2_addr = node_of(cur_head);
                    p2_data = to_link(r_nid);
                end
                CMD_APPEND: begin
                    n1_we   = 1'b1;
                    n2_we   = is_node(cur_tail);
                    n2_addr = node_of(cur_tail);
                    n2_data = to_link(r_nid);
                    p1_we   = 1'b1;
                    p1_data = cur_tail;
                end
                CMD_EXTRACT, CMD_POP_FRONT: begin
                    p1_we   = is_node(rd_next);
                    p1_addr = node_of(rd_next);
                    p1_data = rd_prev;
                    p2_we   = 1'b1;
                    p2_addr = u_node;
                    n1_we   = is_node(rd_prev);
                    n1_addr = node_of(rd_prev);
                    n1_data = rd_next;
                    n2_we   = 1'b1;
                    n2_addr = u_node;
                end
                CMD_INSERT_AFTER: begin
                    n1_we   = 1'b1;
                    n1_data = rd_next;
                    n2_we   = 1'b1;
                    n2_addr = r_aid;
                    n2_data = to_link(r_nid);
                    p1_we   = 1'b1;
                    p1_data = to_link(r_aid);
                    p2_we   = is_node(rd_next);
                    p2_addr = node_of(rd_next);
                    p2_data = to_link(r_nid);
                end
                default: begin
                end
            endcase
        end
    end

    assign next_we    = (i_ctl.wr1 && n1_we) || (i_ctl.wr2 && n2_we);
    assign next_waddr = i_ctl.wr2 ? n2_addr : n1_addr;
    assign next_wdata = i_ctl.wr2 ? n2_data : n1_data;
    assign prev_we    = (i_ctl.wr1 && p1_we) || (i_ctl.wr2 && p2_we);
    assign prev_waddr = i_ctl.wr2 ? p2_addr : p1_addr;
    assign prev_wdata = i_ctl.wr2 ? p2_data : p1_data;

    llqm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (w_next_q)
    );

    llqm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (w_prev_q)
    );

    // entry valid bits, aligned with the registered RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= '0;
            r_pvld <= '0;
            r_nrv  <= 1'b0;
            r_prv  <= 1'b0;
        end else begin
            if (next_we) begin
                r_nvld[next_waddr] <= 1'b1;
            end
            if (prev_we) begin
                r_pvld[prev_waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_nrv <= r_nvld[rd_addr];
                r_prv <= r_pvld[rd_addr];
            end
        end
    end

    // list registers and in-list flags change only in the second write slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIST_COUNT; i++) begin
                r_head[i]  <= NIL;
                r_tail[i]  <= NIL;
                r_count[i] <= '0;
            end
            r_inl <= '0;
        end else if (i_ctl.wr2 && go) begin
            case (r_cmd)
                CMD_RESET_LIST: begin
                    r_head[r_lid]  <= NIL;
                    r_tail[r_lid]  <= NIL;
                    r_count[r_lid] <= '0;
                end
                CMD_RESET_NODE: begin
                    r_inl[r_nid] <= 1'b0;
                end
                CMD_INSERT_FRONT: begin
                    if (!is_node(cur_head)) begin
                        r_tail[r_lid] <= to_link(r_nid);
                    end
                    r_head[r_lid]  <= to_link(r_nid);
                    r_count[r_lid] <= cnt_up;
                    r_inl[r_nid]   <= 1'b1;
                end
                CMD_APPEND: begin
                    if (!is_node(cur_tail)) begin
                        r_head[r_lid] <= to_link(r_nid);
                    end
                    r_tail[r_lid]  <= to_link(r_nid);
                    r_count[r_lid] <= cnt_up;
                    r_inl[r_nid]   <= 1'b1;
                end
                CMD_EXTRACT, CMD_POP_FRONT: begin
                    if (!is_node(rd_next)) begin
                        r_tail[r_lid] <= rd_prev;
                    end
                    if (!is_node(rd_prev)) begin
                        r_head[r_lid] <= rd_next;
                    end
                    r_count[r_lid] <= cnt_dn;
                    r_inl[u_node]  <= 1'b0;
                end
                CMD_INSERT_AFTER: begin
                    if (!is_node(rd_next)) begin
                        r_tail[r_lid] <= to_link(r_nid);
                    end
                    r_count[r_lid] <= cnt_up;
                    r_inl[r_nid]   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr2) begin
            r_acc      <= go;
            r_pop_vld  <= go && (r_cmd == CMD_POP_FRONT);
            r_pop_node <= (go && (r_cmd == CMD_POP_FRONT)) ? node_of(cur_head) : '0;
        end
    end

    // result register
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_o_acc      <= r_acc;
            r_o_pop_node <= r_pop_node;
            r_o_pop_vld  <= r_pop_vld;
            r_o_head_vld <= lok && is_node(cur_head);
            r_o_head     <= (lok && is_node(cur_head)) ? node_of(cur_head) : '0;
            r_o_tail_vld <= lok && is_node(cur_tail);
            r_o_tail     <= (lok && is_node(cur_tail)) ? node_of(cur_tail) : '0;
            r_o_count    <= lok ? cur_cnt : '0;
            r_o_next_vld <= nok && is_node(rd_next);
            r_o_next     <= (nok && is_node(rd_next)) ? node_of(rd_next) : '0;
            r_o_prev_vld <= nok && is_node(rd_prev);
            r_o_prev     <= (nok && is_node(rd_prev)) ? node_of(rd_prev) : '0;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_accepted     = r_o_acc;
    assign o_popped_node  = r_o_pop_node;
    assign o_popped_valid = r_o_pop_vld;
    assign o_head_node    = r_o_head;
    assign o_head_valid   = r_o_head_vld;
    assign o_tail_node    = r_o_tail;
    assign o_tail_valid   = r_o_tail_vld;
    assign o_entry_count  = r_o_count;
    assign o_next_node    = r_o_next;
    assign o_next_valid   = r_o_next_vld;
    assign o_prev_node    = r_o_prev;
    assign o_prev_valid   = r_o_prev_vld;

endmodule

`default_nettype wire

@@ src/linked_list_queue_manager.sv @@
// Linked list queue manager: several doubly linked lists over a pool of nodes.
// Top level joining llqm_ctrl and llqm_dp; depends on llqm_pkg.
//
// Use: one command channel (i_in_valid / o_in_stall with command, list,
// node and anchor fields) and one result channel (o_out_valid / i_out_stall)
// carrying the list's head, tail and count and the node's links as they are
// after the command. Every command gives exactly one result.
// Sequence: a command is captured on acceptance; its result is registered
// once the result channel is free. A new command is taken only after that,
// so one command is finished before the next is accepted. The steps are
// set by the next and prev link RAMs, each with one write port and one
// registered read port: one read of the links the command needs, two ordered
// write slots, and a read back of node_id.
// Reset (synchronous, active low) empties all lists and marks every node free
// at once; link entries carry valid bits, so there is no clearing pass and a
// command can be taken in the first cycle after reset is released.
// Stall: a result waits in the output register while i_out_stall is high;
// the next command is still accepted and worked on, and holds in its last
// step until the output register is free.
`default_nettype none

module linked_list_queue_manager (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [llqm_pkg::CMD_W-1:0]  i_command,
    input  wire logic [llqm_pkg::LIST_W-1:0] i_list_id,
    input  wire logic [llqm_pkg::NODE_W-1:0] i_node_id,
    input  wire logic [llqm_pkg::NODE_W-1:0] i_anchor_id,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_accepted,
    output logic      [llqm_pkg::NODE_W-1:0] o_popped_node,
    output logic                             o_popped_valid,
    output logic      [llqm_pkg::NODE_W-1:0] o_head_node,
    output logic                             o_head_valid,
    output logic      [llqm_pkg::NODE_W-1:0] o_tail_node,
    output logic                             o_tail_valid,
    output logic      [llqm_pkg::CNT_W-1:0]  o_entry_count,
    output logic      [llqm_pkg::NODE_W-1:0] o_next_node,
    output logic                             o_next_valid,
    output logic      [llqm_pkg::NODE_W-1:0] o_prev_node,
    output logic                             o_prev_valid
);

    import llqm_pkg::*;

    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;

    llqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl)
    );

    llqm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_command      (i_command),
        .i_list_id      (i_list_id),
        .i_node_id      (i_node_id),
        .i_anchor_id    (i_anchor_id),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_accepted     (o_accepted),
        .o_popped_node  (o_popped_node),
        .o_popped_valid (o_popped_valid),
        .o_head_node    (o_head_node),
        .o_head_valid   (o_head_valid),
        .o_tail_node    (o_tail_node),
        .o_tail_valid   (o_tail_valid),
        .o_entry_count  (o_entry_count),
        .o_next_node    (o_next_node),
        .o_next_valid   (o_next_valid),
        .o_prev_node    (o_prev_node),
        .o_prev_valid   (o_prev_valid)
    );

`ifndef NO_ASSERTIONS
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctl.capture, w_ctl.rd_tgt, w_ctl.wr1, w_ctl.wr2,
                  w_ctl.rd_node, w_ctl.load_out}))
        else $error("more than one datapath step in a cycle");

    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr1 |=> w_ctl.wr2 ##1 w_ctl.rd_node)
        else $error("write slots or read back out of order");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_out |-> !(o_out_valid && i_out_stall))
        else $error("result loaded over a held result");

    a_pop_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_popped_valid) |-> o_accepted)
        else $error("popped node reported on an ignored command");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for linked_list_queue_manager: a scoreboard class keeps its own
// copy of the lists and links and predicts every result. Depends only on llqm_pkg and the RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import llqm_pkg::*;

    typedef struct packed {
        logic   accepted;
        t_node  popped_node;
        logic   popped_valid;
        t_node  head_node;
        logic   head_valid;
        t_node  tail_node;
        logic   tail_valid;
        t_count entry_count;
        t_node  next_node;
        logic   next_valid;
        t_node  prev_node;
        logic   prev_valid;
    } t_llqm_result;

    class llqm_scoreboard;
        t_link        list_first [LIST_COUNT];
        t_link        list_last  [LIST_COUNT];
        t_count       list_len   [LIST_COUNT];
        t_link        link_fwd   [NODE_COUNT];
        t_link        link_back  [NODE_COUNT];
        bit           node_busy  [NODE_COUNT];
        int           node_home  [NODE_COUNT];
        t_llqm_result pending_results [$];
        int           errors;

        function new();
            errors = 0;
            foreach (list_first[i]) begin
                list_first[i] = NIL;
                list_last[i]  = NIL;
                list_len[i]   = '0;
            end
            foreach (link_fwd[i]) begin
                link_fwd[i]  = NIL;
                link_back[i] = NIL;
                node_busy[i] = 1'b0;
                node_home[i] = -1;
            end
        endfunction

        function void grow(int l);
            if (list_len[l] < t_count'(COUNT_MAX)) list_len[l]++;
        endfunction

        // remove a node, patching whatever its links point at; count holds at zero
        function void unlink(int l, t_node n);
            t_link nx;
            t_link pv;
            nx = link_fwd[n];
            pv = link_back[n];
            if (nx < NIL) link_back[nx[NODE_W-1:0]] = pv;
            else list_last[l] = pv;
            if (pv < NIL) link_fwd[pv[NODE_W-1:0]] = nx;
            else list_first[l] = nx;
            link_fwd[n]  = NIL;
            link_back[n] = NIL;
            node_busy[n] = 1'b0;
            node_home[n] = -1;
            if (list_len[l] != '0) list_len[l]--;
        endfunction

        function int pick_node(bit busy);
            int start;
            int idx;
            start = $urandom_range(NODE_COUNT - 1);
            for (int k = 0; k < NODE_COUNT; k++) begin
                idx = (start + k) % NODE_COUNT;
                if (node_busy[idx] == busy) return idx;
            end
            return -1;
        endfunction

        // apply one accepted transaction and queue the result it must produce
        function void note_command(t_cmd c, int l, t_node n, t_node a);
            t_llqm_result r;
            t_link        h;
            t_link        nx;
            r = '0;
            case (c)
                CMD_RESET_LIST: begin
                    list_first[l] = NIL;
                    list_last[l]  = NIL;
                    list_len[l]   = '0;
                    r.accepted    = 1'b1;
                end
                CMD_RESET_NODE: begin
                    link_fwd[n]  = NIL;
                    link_back[n] = NIL;
                    node_busy[n] = 1'b0;
                    node_home[n] = -1;
                    r.accepted   = 1'b1;
                end
                CMD_INSERT_FRONT: begin
                    if (!node_busy[n]) begin
                        h            = list_first[l];
                        link_back[n] = NIL;
                        link_fwd[n]  = h;
                        if (h < NIL) link_back[h[NODE_W-1:0]] = t_link'(n);
                        else list_last[l] = t_link'(n);
                        list_first[l] = t_link'(n);
                        grow(l);
                        node_busy[n] = 1'b1;
                        node_home[n] = l;
                        r.accepted   = 1'b1;
                    end
                end
                CMD_APPEND: begin
                    if (!node_busy[n]) begin
                        h            = list_last[l];
                        link_fwd[n]  = NIL;
                        link_back[n] = h;
                        if (h < NIL) link_fwd[h[NODE_W-1:0]] = t_link'(n);
                        else list_first[l] = t_link'(n);
                        list_last[l] = t_link'(n);
                        grow(l);
                        node_busy[n] = 1'b1;
                        node_home[n] = l;
                        r.accepted   = 1'b1;
                    end
                end
                CMD_EXTRACT: begin
                    if (node_busy[n]) begin
                        unlink(l, n);
                        r.accepted = 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    h = list_first[l];
                    if (h < NIL) begin
                        r.popped_node  = h[NODE_W-1:0];
                        r.popped_valid = 1'b1;
                        unlink(l, h[NODE_W-1:0]);
                        r.accepted     = 1'b1;
                    end
                end
                CMD_INSERT_AFTER: begin
                    if (!node_busy[n] && node_busy[a]) begin
                        nx           = link_fwd[a];
                        link_fwd[n]  = nx;
                        link_back[n] = t_link'(a);
                        if (nx < NIL) link_back[nx[NODE_W-1:0]] = t_link'(n);
                        else list_last[l] = t_link'(n);
                        link_fwd[a]  = t_link'(n);
                        node_busy[n] = 1'b1;
                        node_home[n] = l;
                        grow(l);
                        r.accepted   = 1'b1;
                    end
                end
                default: r.accepted = 1'b1;
            endcase
            if (list_first[l] < NIL) begin
                r.head_node  = list_first[l][NODE_W-1:0];
                r.head_valid = 1'b1;
            end
            if (list_last[l] < NIL) begin
                r.tail_node  = list_last[l][NODE_W-1:0];
                r.tail_valid = 1'b1;
            end
            r.entry_count = list_len[l];
            if (link_fwd[n] < NIL) begin
                r.next_node  = link_fwd[n][NODE_W-1:0];
                r.next_valid = 1'b1;
            end
            if (link_back[n] < NIL) begin
                r.prev_node  = link_back[n][NODE_W-1:0];
                r.prev_valid = 1'b1;
            end
            pending_results.push_back(r);
        endfunction

        function void check_field(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want, got);
            end
        endfunction

        function void check_result(t_llqm_result got);
            t_llqm_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("popped_node", want.popped_node, got.popped_node);
            check_field("popped_valid", want.popped_valid, got.popped_valid);
            check_field("head_node", want.head_node, got.head_node);
            check_field("head_valid", want.head_valid, got.head_valid);
            check_field("tail_node", want.tail_node, got.tail_node);
            check_field("tail_valid", want.tail_valid, got.tail_valid);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("next_node", want.next_node, got.next_node);
            check_field("next_valid", want.next_valid, got.next_valid);
            check_field("prev_node", want.prev_node, got.prev_node);
            check_field("prev_valid", want.prev_valid, got.prev_valid);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_command;
    logic [LIST_W-1:0] i_list_id;
    logic [NODE_W-1:0] i_node_id;
    logic [NODE_W-1:0] i_anchor_id;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_accepted;
    logic [NODE_W-1:0] o_popped_node;
    logic              o_popped_valid;
    logic [NODE_W-1:0] o_head_node;
    logic              o_head_valid;
    logic [NODE_W-1:0] o_tail_node;
    logic              o_tail_valid;
    logic [CNT_W-1:0]  o_entry_count;
    logic [NODE_W-1:0] o_next_node;
    logic              o_next_valid;
    logic [NODE_W-1:0] o_prev_node;
    logic              o_prev_valid;

    bit                no_idle;
    llqm_scoreboard    sb;

    linked_list_queue_manager u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_list_id      (i_list_id),
        .i_node_id      (i_node_id),
        .i_anchor_id    (i_anchor_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_popped_node  (o_popped_node),
        .o_popped_valid (o_popped_valid),
        .o_head_node    (o_head_node),
        .o_head_valid   (o_head_valid),
        .o_tail_node    (o_tail_node),
        .o_tail_valid   (o_tail_valid),
        .o_entry_count  (o_entry_count),
        .o_next_node    (o_next_node),
        .o_next_valid   (o_next_valid),
        .o_prev_node    (o_prev_node),
        .o_prev_valid   (o_prev_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // sample at the falling edge, act at the rising edge
    task automatic send_cmd(t_cmd c, int l, int n, int a);
        bit took;
        while (!no_idle && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= c;
        i_list_id   <= LIST_W'(l);
        i_node_id   <= NODE_W'(n);
        i_anchor_id <= NODE_W'(a);
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        sb.note_command(c, l, t_node'(n), t_node'(a));
    endtask

    task automatic random_transaction();
        int r;
        int nd;
        int an;
        int ls;
        r  = $urandom_range(99);
        ls = $urandom_range(LIST_COUNT - 1);
        an = $urandom_range(NODE_COUNT - 1);
        if (r < 12) begin
            send_cmd(t_cmd'(CMD_W'($urandom_range(7))), ls, $urandom_range(NODE_COUNT - 1), an);
        end else if (r < 34) begin
            nd = sb.pick_node(1'b0);
            if (nd < 0) nd = $urandom_range(NODE_COUNT - 1);
            send_cmd($urandom_range(1) ? CMD_APPEND : CMD_INSERT_FRONT, ls, nd, an);
        end else if (r < 46) begin
            nd = sb.pick_node(1'b0);
            if (nd < 0) nd = $urandom_range(NODE_COUNT - 1);
            an = sb.pick_node(1'b1);
            if (an < 0) an = $urandom_range(NODE_COUNT - 1);
            else if (sb.node_home[an] >= 0) ls = sb.node_home[an];
            send_cmd(CMD_INSERT_AFTER, ls, nd, an);
        end else if (r < 64) begin
            nd = sb.pick_node(1'b1);
            if (nd < 0) nd = $urandom_range(NODE_COUNT - 1);
            else if (sb.node_home[nd] >= 0) ls = sb.node_home[nd];
            send_cmd(CMD_EXTRACT, ls, nd, an);
        end else if (r < 80) begin
            send_cmd(CMD_POP_FRONT, ls, $urandom_range(NODE_COUNT - 1), an);
        end else if (r < 94) begin
            send_cmd(CMD_QUERY, ls, $urandom_range(NODE_COUNT - 1), an);
        end else if (r < 97) begin
            send_cmd(CMD_RESET_NODE, ls, $urandom_range(NODE_COUNT - 1), an);
        end else begin
            send_cmd(CMD_RESET_LIST, ls, $urandom_range(NODE_COUNT - 1), an);
        end
    endtask

    initial begin
        t_llqm_result got;
        bit           took;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            took             = o_out_valid && !i_out_stall;
            got.accepted     = o_accepted;
            got.popped_node  = o_popped_node;
            got.popped_valid = o_popped_valid;
            got.head_node    = o_head_node;
            got.head_valid   = o_head_valid;
            got.tail_node    = o_tail_node;
            got.tail_valid   = o_tail_valid;
            got.entry_count  = o_entry_count;
            got.next_node    = o_next_node;
            got.next_valid   = o_next_valid;
            got.prev_node    = o_prev_node;
            got.prev_valid   = o_prev_valid;
            @(posedge i_clk);
            if (took) sb.check_result(got);
            i_out_stall <= !no_idle && ($urandom_range(99) < 28);
        end
    end

    initial begin
        sb          = new();
        no_idle     = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= '0;
        i_list_id   <= '0;
        i_node_id   <= '0;
        i_anchor_id <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(CMD_QUERY, 0, 0, 0);
        send_cmd(CMD_POP_FRONT, 7, 63, 63);     // empty list
        send_cmd(CMD_EXTRACT, 0, 63, 0);        // node is free
        send_cmd(CMD_APPEND, 0, 0, 0);
        send_cmd(CMD_INSERT_FRONT, 0, 63, 63);
        send_cmd(CMD_APPEND, 0, 0, 0);          // already linked
        send_cmd(CMD_INSERT_FRONT, 0, 63, 0);
        send_cmd(CMD_INSERT_AFTER, 0, 31, 0);   // after the tail
        send_cmd(CMD_INSERT_AFTER, 0, 42, 63);
        send_cmd(CMD_INSERT_AFTER, 0, 6, 5);    // free anchor
        send_cmd(CMD_INSERT_AFTER, 0, 42, 0);   // node already linked
        send_cmd(CMD_QUERY, 0, 42, 0);
        send_cmd(CMD_EXTRACT, 0, 42, 0);
        send_cmd(CMD_EXTRACT, 0, 63, 0);
        send_cmd(CMD_POP_FRONT, 0, 0, 0);
        send_cmd(CMD_EXTRACT, 0, 31, 0);
        send_cmd(CMD_APPEND, 7, 12, 63);
        send_cmd(CMD_RESET_LIST, 7, 12, 0);     // flag on node 12 stays
        send_cmd(CMD_EXTRACT, 7, 12, 0);        // count holds at zero
        send_cmd(CMD_APPEND, 3, 20, 0);
        send_cmd(CMD_APPEND, 3, 21, 0);
        send_cmd(CMD_RESET_NODE, 3, 20, 0);     // neighbour keeps its link
        send_cmd(CMD_QUERY, 3, 21, 0);
        send_cmd(CMD_EXTRACT, 5, 21, 0);        // wrong list named
        send_cmd(CMD_QUERY, 3, 20, 0);

        // re-insert one freed node over and over to drive the count into saturation
        for (int k = 0; k < 130; k++) begin
            send_cmd(CMD_INSERT_FRONT, 1, 9, $urandom_range(NODE_COUNT - 1));
            send_cmd(CMD_RESET_NODE, 1, 9, $urandom_range(NODE_COUNT - 1));
        end
        send_cmd(CMD_RESET_LIST, 1, 9, 0);

        for (int k = 0; k < 1100; k++) begin
            no_idle = (k >= 450 && k < 700);
            random_transaction();
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
